/* design/gvn_pkg.sv */
package gvn_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned NUM_COORDS     = 12;

  localparam int unsigned MAG_BITS   = 30;
  localparam int unsigned SQ_BITS    = 2 * MAG_BITS;
  localparam int unsigned SUM_BITS   = SQ_BITS + 2;
  localparam int unsigned LEN_BITS   = 31;
  localparam int unsigned DEN_BITS   = LEN_BITS + 1;
  localparam int unsigned Q_BITS     = 15;
  localparam int unsigned NUM_BITS   = MAG_BITS + Q_BITS + 2;
  localparam int unsigned NORM_BITS  = 16;
  localparam int unsigned OUT_TDATA_W = 3 * NORM_BITS;

  localparam logic [Q_BITS-1:0] ONE_Q14 = Q_BITS'(16384);

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic [LEN_BITS-1:0] len_t;

  function automatic int unsigned diff_bits(int unsigned cb);
    return (cb > 30) ? 32 : cb + 1;
  endfunction

endpackage

/* design/gvn_cross.sv */
module gvn_cross #(
  parameter int unsigned COORD_BITS = gvn_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [gvn_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] coord_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [2:0][2*gvn_pkg::diff_bits(COORD_BITS)-1:0] mag_o,
  output logic [2:0] neg_o,
  output logic degen_o
);
  import gvn_pkg::*;

  localparam int unsigned RW = COORD_BITS + 1;
  localparam int unsigned HW = diff_bits(COORD_BITS);
  localparam int unsigned DS = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int unsigned PW = 2 * HW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned NS = 5;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic [RW-1:0]        dr_q [6];
  logic signed [HW-1:0] dd_d [6];
  logic signed [HW-1:0] dd_q [6];
  logic signed [PW-1:0] pr_q [6];
  logic signed [CW-1:0] c_q  [3];
  logic [PW-1:0]        mag_q [3];
  logic [2:0]           neg_q;
  logic                 degen_q;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // raw differences: right - left, above - below
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[i]   <= {coord_i[3+i][COORD_BITS-1], coord_i[3+i]}
                   - {coord_i[i][COORD_BITS-1], coord_i[i]};
        dr_q[3+i] <= {coord_i[6+i][COORD_BITS-1], coord_i[6+i]}
                   - {coord_i[9+i][COORD_BITS-1], coord_i[9+i]};
      end
    end
  end

  generate
    if (DS == 0) begin : g_noshrink
      always_comb begin
        for (int i = 0; i < 6; i++) begin
          dd_d[i] = HW'(dr_q[i]);
        end
      end
    end else begin : g_shrink
      logic [RW-1:0] am [6];
      logic [HW-1:0] sm [6];
      always_comb begin
        for (int i = 0; i < 6; i++) begin
          am[i] = dr_q[i][RW-1] ? (~dr_q[i] + RW'(1)) : dr_q[i];
          sm[i] = HW'(am[i] >> DS);
          dd_d[i] = dr_q[i][RW-1] ? $signed(~sm[i] + HW'(1)) : $signed(sm[i]);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 6; i++) begin
        dd_q[i] <= dd_d[i];
      end
    end
  end

  // h in dd_q[0..2], v in dd_q[3..5]
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pr_q[0] <= dd_q[1] * dd_q[5];
      pr_q[1] <= dd_q[2] * dd_q[4];
      pr_q[2] <= dd_q[2] * dd_q[3];
      pr_q[3] <= dd_q[0] * dd_q[5];
      pr_q[4] <= dd_q[0] * dd_q[4];
      pr_q[5] <= dd_q[1] * dd_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CW'(pr_q[2*i]) - CW'(pr_q[2*i+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= c_q[i][CW-1];
        mag_q[i] <= c_q[i][CW-1] ? PW'(-c_q[i]) : PW'(c_q[i]);
      end
      degen_q <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = mag_q[i];
    end
  end

  assign neg_o   = neg_q;
  assign degen_o = degen_q;

endmodule

/* design/gvn_norm.sv */
module gvn_norm #(
  parameter int unsigned COORD_BITS = gvn_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [2:0][2*gvn_pkg::diff_bits(COORD_BITS)-1:0] mag_i,
  input  logic [2:0] neg_i,
  input  logic degen_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [2:0][gvn_pkg::MAG_BITS-1:0] mag_o,
  output logic [2:0] neg_o,
  output logic degen_o
);
  import gvn_pkg::*;

  localparam int unsigned MW = 2 * diff_bits(COORD_BITS);
  localparam int unsigned XW = (MW > MAG_BITS) ? MW : MAG_BITS + 1;
  localparam int unsigned NK = $clog2(XW - MAG_BITS);
  localparam int unsigned NS = NK + 1;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic [XW-1:0] m_q [NS][3];
  logic [2:0]    neg_q [NS];
  logic          dg_q  [NS];

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // binary search for the block shift, largest step first, then a final single step
  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int unsigned SHF = (j < NK) ? (1 << (NK - 1 - j)) : 1;
    localparam int unsigned TH  = (j < NK) ? SHF + MAG_BITS : MAG_BITS;
    logic [XW-1:0] mi [3];
    logic [2:0]    ni;
    logic          di;
    logic [XW-1:0] orv;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          mi[i] = XW'(mag_i[i]);
        end
      end
      assign ni = neg_i;
      assign di = degen_i;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          mi[i] = m_q[j-1][i];
        end
      end
      assign ni = neg_q[j-1];
      assign di = dg_q[j-1];
    end

    assign orv = mi[0] | mi[1] | mi[2];

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        for (int i = 0; i < 3; i++) begin
          m_q[j][i] <= ((orv >> TH) != '0) ? (mi[i] >> SHF) : mi[i];
        end
        neg_q[j] <= ni;
        dg_q[j]  <= di;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = m_q[NS-1][i][MAG_BITS-1:0];
    end
  end

  assign neg_o   = neg_q[NS-1];
  assign degen_o = dg_q[NS-1];

endmodule

/* design/gvn_sqrt.sv */
module gvn_sqrt (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [2:0][gvn_pkg::MAG_BITS-1:0] mag_i,
  input  logic [2:0] neg_i,
  input  logic degen_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [2:0][gvn_pkg::MAG_BITS-1:0] mag_o,
  output logic [2:0] neg_o,
  output logic degen_o,
  output gvn_pkg::len_t len_o
);
  import gvn_pkg::*;

  localparam int unsigned NS = LEN_BITS + 2;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  mag_t              mag_q [NS][3];
  logic [2:0]        neg_q [NS];
  logic              dg_q  [NS];
  logic [SQ_BITS-1:0]  sq_q [3];
  logic [SUM_BITS-1:0] sum_q;
  logic [SUM_BITS-1:0] rem_q  [LEN_BITS];
  len_t                root_q [LEN_BITS];

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // carried fields
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[0][i] <= mag_i[i];
      end
      neg_q[0] <= neg_i;
      dg_q[0]  <= degen_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        mag_q[k] <= mag_q[k-1];
        neg_q[k] <= neg_q[k-1];
        dg_q[k]  <= dg_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_BITS'(mag_i[i]) * SQ_BITS'(mag_i[i]);
      end
    end
    if (en[1]) begin
      sum_q <= SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
    end
  end

  // one root bit per stage, msb first
  for (genvar j = 0; j < LEN_BITS; j++) begin : g_bit
    localparam int unsigned B = LEN_BITS - 1 - j;
    logic [SUM_BITS-1:0] ri;
    len_t                qi;
    logic [63:0]         t;

    if (j == 0) begin : g_first
      assign ri = sum_q;
      assign qi = '0;
    end else begin : g_next
      assign ri = rem_q[j-1];
      assign qi = root_q[j-1];
    end

    assign t = (64'(qi) << (B + 1)) + (64'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en[j+2]) begin
        if (64'(ri) >= t) begin
          rem_q[j]  <= SUM_BITS'(64'(ri) - t);
          root_q[j] <= qi | (len_t'(1) << B);
        end else begin
          rem_q[j]  <= ri;
          root_q[j] <= qi;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = mag_q[NS-1][i];
    end
  end

  assign neg_o   = neg_q[NS-1];
  assign degen_o = dg_q[NS-1];
  assign len_o   = root_q[LEN_BITS-1];

endmodule

/* design/gvn_div.sv */
module gvn_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [2:0][gvn_pkg::MAG_BITS-1:0] mag_i,
  input  logic [2:0] neg_i,
  input  logic degen_i,
  input  gvn_pkg::len_t len_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [2:0][gvn_pkg::NORM_BITS-1:0] norm_o,
  output logic degen_o
);
  import gvn_pkg::*;

  localparam int unsigned NS = Q_BITS + 2;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic [NUM_BITS-1:0] rem_q [Q_BITS+1][3];
  logic [Q_BITS-1:0]   quo_q [Q_BITS+1][3];
  logic [DEN_BITS-1:0] den_q [Q_BITS+1];
  logic [2:0]          neg_q [Q_BITS+1];
  logic                dg_q  [Q_BITS+1];
  logic [NORM_BITS-1:0] norm_q [3];
  logic                 degen_q;
  len_t                 len_c;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign len_c = (len_i == '0) ? len_t'(1) : len_i;

  // numerator mag * 32768 + len, denominator 2 * len
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= {2'b00, mag_i[i], {Q_BITS{1'b0}}} + NUM_BITS'(len_c);
        quo_q[0][i] <= '0;
      end
      den_q[0] <= {len_c, 1'b0};
      neg_q[0] <= neg_i;
      dg_q[0]  <= degen_i;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < Q_BITS; j++) begin : g_bit
    localparam int unsigned B = Q_BITS - 1 - j;
    logic [NUM_BITS-1:0] t;

    assign t = NUM_BITS'(den_q[j]) << B;

    always_ff @(posedge clk_i) begin
      if (en[j+1]) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[j][i] >= t) begin
            rem_q[j+1][i] <= rem_q[j][i] - t;
            quo_q[j+1][i] <= quo_q[j][i] | (Q_BITS'(1) << B);
          end else begin
            rem_q[j+1][i] <= rem_q[j][i];
            quo_q[j+1][i] <= quo_q[j][i];
          end
        end
        den_q[j+1] <= den_q[j];
        neg_q[j+1] <= neg_q[j];
        dg_q[j+1]  <= dg_q[j];
      end
    end
  end

  // clamp, sign and zero for degenerate items
  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      for (int i = 0; i < 3; i++) begin
        if (dg_q[Q_BITS]) begin
          norm_q[i] <= '0;
        end else if (neg_q[Q_BITS][i]) begin
          norm_q[i] <= -NORM_BITS'((quo_q[Q_BITS][i] > ONE_Q14) ? ONE_Q14 : quo_q[Q_BITS][i]);
        end else begin
          norm_q[i] <= NORM_BITS'((quo_q[Q_BITS][i] > ONE_Q14) ? ONE_Q14 : quo_q[Q_BITS][i]);
        end
      end
      degen_q <= dg_q[Q_BITS];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_o[i] = norm_q[i];
    end
  end

  assign degen_o = degen_q;

endmodule

/* design/grid_vertex_normal_core.sv */
// Unit surface normal of a grid vertex by central differences. Each input item holds the
// left, right, above and below neighbour positions as signed COORD_BITS-wide fixed point;
// the block takes the cross product of (right - left) and (above - below), scales it to
// unit length and returns x, y, z in signed Q2.14 (16384 is 1.0), rounded half away from
// zero. A zero cross product gives a zero normal with tuser set. The pipeline takes one
// item per clock when m_axis_tready does not stall it and returns one result per item, in
// order. Its steps are the differences and cross product, block scaling, the squares, sum
// and bit-per-stage square root, and the three bit-per-stage dividers and output register.
// Every stage holds its item under back pressure, so bubbles are squeezed out.
module grid_vertex_normal_core #(
  parameter int unsigned COORD_BITS = gvn_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // left_x, left_y, left_z, right_x .. right_z, above_x .. above_z, below_x .. below_z
  input  logic [((gvn_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [gvn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser
);
  import gvn_pkg::*;

  localparam int unsigned MW = 2 * diff_bits(COORD_BITS);

  logic [NUM_COORDS-1:0][COORD_BITS-1:0] coord;

  logic            x_valid, x_ready;
  logic [2:0][MW-1:0] x_mag;
  logic [2:0]      x_neg;
  logic            x_degen;

  logic            n_valid, n_ready;
  logic [2:0][MAG_BITS-1:0] n_mag;
  logic [2:0]      n_neg;
  logic            n_degen;

  logic            r_valid, r_ready;
  logic [2:0][MAG_BITS-1:0] r_mag;
  logic [2:0]      r_neg;
  logic            r_degen;
  len_t            r_len;

  logic [2:0][NORM_BITS-1:0] norm;

  assign coord = s_axis_tdata[NUM_COORDS*COORD_BITS-1:0];

  gvn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .coord_i (coord),
    .valid_o (x_valid),
    .ready_i (x_ready),
    .mag_o   (x_mag),
    .neg_o   (x_neg),
    .degen_o (x_degen)
  );

  gvn_norm #(.COORD_BITS(COORD_BITS)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_valid),
    .ready_o (x_ready),
    .mag_i   (x_mag),
    .neg_i   (x_neg),
    .degen_i (x_degen),
    .valid_o (n_valid),
    .ready_i (n_ready),
    .mag_o   (n_mag),
    .neg_o   (n_neg),
    .degen_o (n_degen)
  );

  gvn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid),
    .ready_o (n_ready),
    .mag_i   (n_mag),
    .neg_i   (n_neg),
    .degen_i (n_degen),
    .valid_o (r_valid),
    .ready_i (r_ready),
    .mag_o   (r_mag),
    .neg_o   (r_neg),
    .degen_o (r_degen),
    .len_o   (r_len)
  );

  gvn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .ready_o (r_ready),
    .mag_i   (r_mag),
    .neg_i   (r_neg),
    .degen_i (r_degen),
    .len_i   (r_len),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .norm_o  (norm),
    .degen_o (m_axis_tuser)
  );

  assign m_axis_tdata = {norm[2], norm[1], norm[0]};

endmodule
